[src/skh_pkg.sv]
// shared constants and controller/datapath interface types for streaming_kth_largest
// no dependencies; used by every other file through scoped names
package skh_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = POS_W + 1;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the incoming word
        logic start_up;  // open a hole at count+1, grow the count
        logic start_dn;  // open a hole at the root
        logic rd_up;     // read the parent of the hole
        logic rd_dn;     // read both children of the hole
        logic wr_val;    // drop the new value into the hole, finish
        logic wr_up;     // move parent down into the hole, hole goes up
        logic wr_dn;     // move smaller child up into the hole, hole goes down
        logic load_out;  // register the result word
    } skh_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic do_insert;
        logic do_replace;
        logic pos_root;
        logic up_stop;
        logic dn_leaf;
        logic dn_stop;
        logic out_free;
    } skh_status_t;

endpackage

[src/streaming_kth_largest.sv]
// top level of the streaming k-th largest tracker: controller plus heap datapath
// depends on skh_pkg, skh_ctrl and skh_datapath
//
// Keeps the k largest signed 32-bit words seen so far in a binary min-heap of up
// to 1024 entries and returns, for every input word, the heap minimum (the k-th
// largest once k words are held) and the number held. One word is processed at a
// time: it is captured and started, then the hole moves one heap level per
// registered read of the heap memory followed by a compare and write, and the
// word is dropped into the hole before the result is loaded; a word that is not
// taken in goes straight to loading the result. The result register frees the
// input side, so a new word is taken while an earlier result waits.
// Write k_rank only while idle; 0 acts as 1 and values above 1024 act as 1024.
// No clearing pass is needed after reset.
module streaming_kth_largest (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [skh_pkg::COUNT_W-1:0]       k_rank,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [skh_pkg::DATA_W-1:0] sample_value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [skh_pkg::DATA_W-1:0] kth_value,
    output logic [skh_pkg::COUNT_W-1:0]       held_count
);

    skh_pkg::skh_cmd_t    cmd;
    skh_pkg::skh_status_t sts;

    assign cfg_ready = 1'b1;

    skh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    skh_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .k_rank       (k_rank),
        .sample_value (sample_value),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kth_value    (kth_value),
        .held_count   (held_count)
    );

endmodule

[src/skh_ctrl.sv]
// sequencer for heap insert (sift up) and replace-root (sift down)
// depends on skh_pkg for the command and status structs
module skh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  skh_pkg::skh_status_t sts,
    output skh_pkg::skh_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_UP_CHK = 3'd2;
    localparam logic [2:0] S_UP_CMP = 3'd3;
    localparam logic [2:0] S_DN_CHK = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign sample_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (sts.do_insert)
                begin
                    cmd.start_up = 1'b1;
                    state_next   = S_UP_CHK;
                end
                else if (sts.do_replace)
                begin
                    cmd.start_dn = 1'b1;
                    state_next   = S_DN_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_UP_CHK:
            begin
                if (sts.pos_root)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_up  = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_stop)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wr_up  = 1'b1;
                    state_next = S_UP_CHK;
                end
            end
            S_DN_CHK:
            begin
                if (sts.dn_leaf)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_dn  = 1'b1;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wr_dn  = 1'b1;
                    state_next = S_DN_CHK;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[src/skh_datapath.sv]
// heap memory, count, rank register, hole pointer and result register
// depends on skh_pkg for sizes and the command and status structs
module skh_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [skh_pkg::COUNT_W-1:0]  k_rank,
    input  logic signed [skh_pkg::DATA_W-1:0] sample_value,
    input  skh_pkg::skh_cmd_t             cmd,
    output skh_pkg::skh_status_t          sts,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [skh_pkg::DATA_W-1:0] kth_value,
    output logic [skh_pkg::COUNT_W-1:0]  held_count
);

    localparam int DW = skh_pkg::DATA_W;
    localparam int PW = skh_pkg::POS_W;
    localparam int CW = skh_pkg::CHILD_W;
    localparam int AW = skh_pkg::ADDR_W;
    localparam int KW = skh_pkg::COUNT_W;

    logic signed [DW-1:0] mem [skh_pkg::CAPACITY];

    logic [KW-1:0]        k_reg;
    logic [PW-1:0]        count_reg;
    logic [PW-1:0]        count_next;
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pos_next;
    logic signed [DW-1:0] val_reg;
    logic signed [DW-1:0] root_reg;
    logic signed [DW-1:0] rd_a_reg;
    logic signed [DW-1:0] rd_b_reg;
    logic                 out_valid_reg;
    logic signed [DW-1:0] kth_reg;
    logic [KW-1:0]        held_reg;

    logic [PW-1:0]        k_eff;
    logic [CW-1:0]        child;
    logic [PW-1:0]        parent;
    logic                 sel_right;
    logic signed [DW-1:0] child_data;
    logic                 wr_en;
    logic signed [DW-1:0] wr_data;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_a_addr;
    logic [AW-1:0]        rd_b_addr;

    // rank out of range is clamped to 1 .. CAPACITY
    always_comb
    begin
        if (k_reg == '0)
            k_eff = PW'(1);
        else if ({{(32-KW){1'b0}}, k_reg} > 32'(skh_pkg::CAPACITY))
            k_eff = PW'(skh_pkg::CAPACITY);
        else
            k_eff = PW'(k_reg);
    end

    assign child  = {pos_reg, 1'b0};
    assign parent = pos_reg >> 1;

    // right child exists when child+1 <= count
    assign sel_right  = (child < CW'(count_reg)) && (rd_a_reg > rd_b_reg);
    assign child_data = sel_right ? rd_b_reg : rd_a_reg;

    assign wr_en   = cmd.wr_val | cmd.wr_up | cmd.wr_dn;
    assign wr_data = cmd.wr_val ? val_reg : (cmd.wr_dn ? child_data : rd_a_reg);
    assign wr_addr = AW'(pos_reg - PW'(1));

    assign rd_a_addr = cmd.rd_dn ? AW'(child - CW'(1)) : AW'(parent - PW'(1));
    assign rd_b_addr = AW'(child);

    always_comb
    begin
        sts.do_insert  = (count_reg < k_eff);
        sts.do_replace = (val_reg > root_reg);
        sts.pos_root   = (pos_reg == PW'(1));
        sts.up_stop    = (val_reg > rd_a_reg);
        sts.dn_leaf    = (child > CW'(count_reg));
        sts.dn_stop    = (child_data > val_reg);
        sts.out_free   = !out_valid_reg || result_ready;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.start_up)
            count_next = count_reg + PW'(1);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.start_up)
            pos_next = count_reg + PW'(1);
        else if (cmd.start_dn)
            pos_next = PW'(1);
        else if (cmd.wr_up)
            pos_next = parent;
        else if (cmd.wr_dn)
            pos_next = sel_right ? PW'(child + CW'(1)) : PW'(child);
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.capture)
            val_reg <= sample_value;
        // root copy lets the replace decision skip a memory read
        if (wr_en && (pos_reg == PW'(1)))
            root_reg <= wr_data;
        if (cmd.load_out)
        begin
            kth_reg  <= root_reg;
            held_reg <= KW'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= KW'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                k_reg <= k_rank;
            count_reg <= count_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign kth_value    = kth_reg;
    assign held_count   = held_reg;

endmodule

[src/skh_checker.sv]
// port-level checks for streaming_kth_largest, attached by bind
// depends on skh_pkg for the capacity
module skh_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [skh_pkg::DATA_W-1:0] kth_value,
    input logic [skh_pkg::COUNT_W-1:0]       held_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(kth_value) && $stable(held_count))
        else $error("result word changed while stalled");

    // every result reports a non-empty heap, since the first word is always taken in
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> held_count != '0)
        else $error("result with empty heap");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(held_count) <= 32'(skh_pkg::CAPACITY))
        else $error("held count above capacity");

    // one word in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second word taken while busy");

endmodule

bind streaming_kth_largest skh_checker u_skh_checker (.*);
